[hdl/ids_pkg.sv]
// shared constants, types and register map for the diffusion stencil unit
package ids_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int PIXEL_BITS   = 16;
	localparam int COL_BITS     = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS   = 11;
	localparam int HEIGHT_BITS  = 13;
	localparam int ROW_BITS     = 12;
	localparam int GAIN_BITS    = 16;
	localparam int FRAC_BITS    = 16;
	localparam int MIN_DIM      = 3;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int PADDR_BITS   = 4;
	localparam int PDATA_BITS   = 32;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
	localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(6554);

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_DIFFUSION_GAIN
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_PIXEL,
		OP_DRAIN
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [PIXEL_BITS-1:0]  in_pixel;
	} in_item_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0]  out_pixel;
		logic                   end_of_frame;
	} out_item_t;

	// effective geometry and gain as the datapath uses them
	typedef struct packed {
		logic [WIDTH_BITS-1:0]  width;
		logic [HEIGHT_BITS-1:0] height;
		logic [GAIN_BITS-1:0]   gain;
	} cfg_t;

	typedef struct packed {
		logic                   rd_en;
		logic [COL_BITS-1:0]    rd_addr;
		logic [COL_BITS-1:0]    rd_right_addr;
		logic                   centre_we;
		logic [COL_BITS-1:0]    centre_waddr;
		logic [PIXEL_BITS-1:0]  centre_wdata;
		logic                   above_we;
		logic [COL_BITS-1:0]    above_waddr;
		logic [PIXEL_BITS-1:0]  above_wdata;
	} lb_req_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0]  centre;
		logic [PIXEL_BITS-1:0]  right;
		logic [PIXEL_BITS-1:0]  above;
	} lb_rsp_t;

endpackage

[hdl/ids_cfg_regs.sv]
// apb register file: frame geometry and diffusion gain
module ids_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ids_pkg::PADDR_BITS-1:0]    paddr,
	input  logic [ids_pkg::PDATA_BITS-1:0]    pwdata,
	output logic [ids_pkg::PDATA_BITS-1:0]    prdata,
	output logic                              pready,
	output ids_pkg::cfg_t                     cfg
);

	logic [ids_pkg::WIDTH_BITS-1:0]  width_q;
	logic [ids_pkg::HEIGHT_BITS-1:0] height_q;
	logic [ids_pkg::GAIN_BITS-1:0]   gain_q;
	ids_pkg::reg_idx_t               idx;
	logic                            wr;

	assign pready = 1'b1;
	assign idx    = ids_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ids_pkg::WIDTH_RESET;
			height_q <= ids_pkg::HEIGHT_RESET;
			gain_q   <= ids_pkg::GAIN_RESET;
		end else if (wr) begin
			unique case (idx)
				ids_pkg::REG_FRAME_WIDTH:    width_q  <= pwdata[ids_pkg::WIDTH_BITS-1:0];
				ids_pkg::REG_FRAME_HEIGHT:   height_q <= pwdata[ids_pkg::HEIGHT_BITS-1:0];
				ids_pkg::REG_DIFFUSION_GAIN: gain_q   <= pwdata[ids_pkg::GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ids_pkg::REG_FRAME_WIDTH:    prdata = ids_pkg::PDATA_BITS'(width_q);
			ids_pkg::REG_FRAME_HEIGHT:   prdata = ids_pkg::PDATA_BITS'(height_q);
			ids_pkg::REG_DIFFUSION_GAIN: prdata = ids_pkg::PDATA_BITS'(gain_q);
			default:                     prdata = '0;
		endcase
	end

	// clamp geometry to the supported range
	always_comb begin
		cfg.width = width_q;
		if (width_q < ids_pkg::WIDTH_BITS'(ids_pkg::MIN_DIM))
			cfg.width = ids_pkg::WIDTH_BITS'(ids_pkg::MIN_DIM);
		if (width_q > ids_pkg::WIDTH_BITS'(ids_pkg::MAX_WIDTH))
			cfg.width = ids_pkg::WIDTH_BITS'(ids_pkg::MAX_WIDTH);
		cfg.height = height_q;
		if (height_q < ids_pkg::HEIGHT_BITS'(ids_pkg::MIN_DIM))
			cfg.height = ids_pkg::HEIGHT_BITS'(ids_pkg::MIN_DIM);
		if (height_q > ids_pkg::HEIGHT_BITS'(ids_pkg::HEIGHT_LIMIT))
			cfg.height = ids_pkg::HEIGHT_BITS'(ids_pkg::HEIGHT_LIMIT);
		cfg.gain = gain_q;
	end

endmodule

[hdl/ids_line_buf.sv]
// two line buffers: centre row (two read ports) and above row, registered reads
module ids_line_buf (
	input  logic             clk,
	input  ids_pkg::lb_req_t req,
	output ids_pkg::lb_rsp_t rsp
);

	logic [ids_pkg::PIXEL_BITS-1:0] centre_mem [ids_pkg::MAX_WIDTH];
	logic [ids_pkg::PIXEL_BITS-1:0] above_mem  [ids_pkg::MAX_WIDTH];
	logic [ids_pkg::PIXEL_BITS-1:0] centre_q;
	logic [ids_pkg::PIXEL_BITS-1:0] right_q;
	logic [ids_pkg::PIXEL_BITS-1:0] above_q;

	// read-first: a read at the written address returns the old entry
	always_ff @(posedge clk) begin
		if (req.centre_we)
			centre_mem[req.centre_waddr] <= req.centre_wdata;
		if (req.rd_en) begin
			centre_q <= centre_mem[req.rd_addr];
			right_q  <= centre_mem[req.rd_right_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.above_we)
			above_mem[req.above_waddr] <= req.above_wdata;
		if (req.rd_en)
			above_q <= above_mem[req.rd_addr];
	end

	assign rsp.centre = centre_q;
	assign rsp.right  = right_q;
	assign rsp.above  = above_q;

endmodule

[hdl/ids_diffuse.sv]
// five-point diffusion update with floor rounding and saturation
module ids_diffuse (
	input  logic [ids_pkg::PIXEL_BITS-1:0] u,
	input  logic [ids_pkg::PIXEL_BITS-1:0] up,
	input  logic [ids_pkg::PIXEL_BITS-1:0] left,
	input  logic [ids_pkg::PIXEL_BITS-1:0] right,
	input  logic [ids_pkg::PIXEL_BITS-1:0] down,
	input  logic [ids_pkg::GAIN_BITS-1:0]  gain,
	output logic [ids_pkg::PIXEL_BITS-1:0] result
);

	localparam int SUM_BITS  = ids_pkg::PIXEL_BITS + 2;
	localparam int LAP_BITS  = ids_pkg::PIXEL_BITS + 3;
	localparam int PROD_BITS = LAP_BITS + ids_pkg::GAIN_BITS + 1;
	localparam int Q_BITS    = PROD_BITS - ids_pkg::FRAC_BITS;
	localparam int V_BITS    = Q_BITS + 1;

	logic        [SUM_BITS-1:0]  nsum;
	logic        [SUM_BITS-1:0]  u4;
	logic signed [LAP_BITS-1:0]  lap;
	logic signed [PROD_BITS-1:0] prod;
	logic signed [Q_BITS-1:0]    q;
	logic signed [V_BITS-1:0]    v;

	always_comb begin
		nsum = SUM_BITS'(up) + SUM_BITS'(left) + SUM_BITS'(right) + SUM_BITS'(down);
		u4   = {u, 2'b00};
		lap  = $signed({1'b0, nsum}) - $signed({1'b0, u4});
		prod = PROD_BITS'(lap) * $signed({1'b0, gain});
		// arithmetic shift rounds toward minus infinity
		q    = prod[PROD_BITS-1:ids_pkg::FRAC_BITS];
		v    = $signed(V_BITS'({1'b0, u})) + V_BITS'(q);
		if (v < 0)
			result = '0;
		else if (v > $signed(V_BITS'({1'b0, {ids_pkg::PIXEL_BITS{1'b1}}})))
			result = '1;
		else
			result = v[ids_pkg::PIXEL_BITS-1:0];
	end

endmodule

[hdl/isotropic_diffusion_stencil_unit.sv]
// top level: raster sequencing, line buffer control, result stage and output register
// One diffusion pass over a raster-order image, one beat per clock: a new pixel or drain
// beat is taken every cycle while the output side keeps up, and a result passes through
// the registered line buffer read and then the multiply-add stage into the output register.
// A pixel beat of row r yields the pixel of row r-1 at the same column (row 0 beats yield
// nothing); border rows and columns pass through unchanged. After the last row, one drain
// beat per column returns the final row, with end_of_frame set on its last pixel. The user
// must write frame width, height and gain over the apb port only while no beat is in
// flight; the block itself does not enforce this. The line buffers need no clearing after
// reset.
module isotropic_diffusion_stencil_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ids_pkg::PADDR_BITS-1:0] paddr,
	input  logic [ids_pkg::PDATA_BITS-1:0] pwdata,
	output logic [ids_pkg::PDATA_BITS-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ids_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ids_pkg::out_item_t             out_data
);

	ids_pkg::cfg_t   cfg;
	ids_pkg::lb_req_t lb_req;
	ids_pkg::lb_rsp_t lb_rsp;

	logic [ids_pkg::COL_BITS-1:0]    col_q;
	logic [ids_pkg::ROW_BITS-1:0]    row_q;
	logic [ids_pkg::COL_BITS-1:0]    drain_q;
	logic [ids_pkg::PIXEL_BITS-1:0]  left_q;

	logic                            valid_s1;
	ids_pkg::op_t                    op_s1;
	logic [ids_pkg::COL_BITS-1:0]    col_s1;
	logic                            row_first_s1;
	logic                            row_second_s1;
	logic                            border_col_s1;
	logic                            last_s1;
	logic [ids_pkg::PIXEL_BITS-1:0]  down_s1;

	ids_pkg::out_item_t              out_q;
	logic                            out_valid_q;

	logic                              accept;
	logic                              is_drain;
	logic                              col_wrap;
	logic [ids_pkg::COL_BITS-1:0]      col_c;
	logic [ids_pkg::HEIGHT_BITS-1:0]   row_pre;
	logic [ids_pkg::HEIGHT_BITS-1:0]   row_c;
	logic [ids_pkg::HEIGHT_BITS-1:0]   row_inc;
	logic [ids_pkg::HEIGHT_BITS-1:0]   row_next;
	logic [ids_pkg::WIDTH_BITS-1:0]    col_next;
	logic                              col_end;
	logic [ids_pkg::COL_BITS-1:0]      drain_c;
	logic                              drain_last;
	logic                              col_is_first;
	logic                              col_is_last;

	logic                              adv;
	logic                              emit;
	logic [ids_pkg::PIXEL_BITS-1:0]    diff_pix;
	logic [ids_pkg::PIXEL_BITS-1:0]    pix_res;

	ids_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ids_line_buf u_lb (
		.clk (clk),
		.req (lb_req),
		.rsp (lb_rsp)
	);

	ids_diffuse u_diff (
		.u      (lb_rsp.centre),
		.up     (lb_rsp.above),
		.left   (left_q),
		.right  (lb_rsp.right),
		.down   (down_s1),
		.gain   (cfg.gain),
		.result (diff_pix)
	);

	assign adv      = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | adv;
	assign accept   = in_valid & in_ready;
	assign is_drain = (in_data.op == ids_pkg::OP_DRAIN);

	// raster position of the incoming beat, with stale indices folded back into the frame
	always_comb begin
		col_wrap = {1'b0, col_q} >= cfg.width;
		col_c    = col_wrap ? '0 : col_q;
		row_pre  = col_wrap ? ids_pkg::HEIGHT_BITS'(row_q) + 1'b1
		                    : ids_pkg::HEIGHT_BITS'(row_q);
		row_c    = (row_pre >= cfg.height) ? '0 : row_pre;
		col_next = ids_pkg::WIDTH_BITS'(col_c) + 1'b1;
		col_end  = col_next >= cfg.width;
		row_inc  = row_c + 1'b1;
		if (col_end)
			row_next = (row_inc >= cfg.height) ? '0 : row_inc;
		else
			row_next = row_c;
		col_is_first = (col_c == '0);
		col_is_last  = ({1'b0, col_c} == cfg.width - 1'b1);

		drain_c    = ({1'b0, drain_q} >= cfg.width) ? '0 : drain_q;
		drain_last = ({1'b0, drain_c} == cfg.width - 1'b1);
	end

	always_comb begin
		lb_req.rd_en         = accept;
		lb_req.rd_addr       = is_drain ? drain_c : col_c;
		lb_req.rd_right_addr = col_c + 1'b1;
		lb_req.centre_we     = accept & ~is_drain;
		lb_req.centre_waddr  = col_c;
		lb_req.centre_wdata  = in_data.in_pixel;
		// old centre value moves up once it has been read
		lb_req.above_we      = valid_s1 & (op_s1 == ids_pkg::OP_PIXEL);
		lb_req.above_waddr   = col_s1;
		lb_req.above_wdata   = lb_rsp.centre;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (accept) begin
			if (is_drain) begin
				drain_q <= drain_last ? '0 : drain_c + 1'b1;
			end else begin
				col_q <= col_end ? '0 : col_next[ids_pkg::COL_BITS-1:0];
				row_q <= row_next[ids_pkg::ROW_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1         <= in_data.op;
			col_s1        <= col_c;
			row_first_s1  <= (row_c == '0);
			row_second_s1 <= (row_c == ids_pkg::HEIGHT_BITS'(1));
			border_col_s1 <= col_is_first | col_is_last;
			last_s1       <= drain_last;
			down_s1       <= in_data.in_pixel;
		end
	end

	// centre value of the previous pixel beat is the left neighbor of the next
	always_ff @(posedge clk) begin
		if (adv && op_s1 == ids_pkg::OP_PIXEL)
			left_q <= lb_rsp.centre;
	end

	always_comb begin
		emit    = (op_s1 == ids_pkg::OP_DRAIN) | ~row_first_s1;
		pix_res = (row_second_s1 | border_col_s1) ? lb_rsp.centre : diff_pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			if (op_s1 == ids_pkg::OP_DRAIN) begin
				out_q.out_pixel    <= lb_rsp.centre;
				out_q.end_of_frame <= last_s1;
			end else begin
				out_q.out_pixel    <= pix_res;
				out_q.end_of_frame <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[test/isotropic_diffusion_stencil_unit_tb.sv]
// self-checking testbench for the isotropic diffusion stencil unit
module isotropic_diffusion_stencil_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 10;
	localparam int SETTLE       = 6;
	localparam int LONG_HOLD    = 400;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_BEATS = 1840;
	localparam int SHOWN_ERRORS = 10;
	localparam longint PIX_MAX  = (longint'(1) << ids_pkg::PIXEL_BITS) - 1;

	typedef enum logic [1:0] {RX_STREAM, RX_CADENCE, RX_COIN, RX_TRICKLE} rx_mode_t;
	typedef enum logic [1:0] {PIX_NOISE, PIX_EXTREME, PIX_FLAT} pix_style_t;

	// hand-built 7x3 frame: floor rounding, low and high saturation
	localparam logic [ids_pkg::PIXEL_BITS-1:0] FRAME_B [21] = '{
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
		16'h0000, 16'h4000, 16'hFFFF, 16'h4000, 16'hFFFF, 16'h0000, 16'hFFFF,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000
	};

	class diffusion_scoreboard;
		logic [ids_pkg::WIDTH_BITS-1:0]  width_reg;
		logic [ids_pkg::HEIGHT_BITS-1:0] height_reg;
		logic [ids_pkg::GAIN_BITS-1:0]   gain_reg;
		logic [ids_pkg::PIXEL_BITS-1:0]  above_row [ids_pkg::MAX_WIDTH];
		logic [ids_pkg::PIXEL_BITS-1:0]  centre_row [ids_pkg::MAX_WIDTH];
		logic [ids_pkg::PIXEL_BITS-1:0]  left_px;
		int unsigned                     row_idx, col_idx, drain_idx;
		ids_pkg::out_item_t              pending [$];
		int unsigned                     pixel_beats, drain_beats, results_seen, mismatches;

		function new();
			width_reg = ids_pkg::WIDTH_RESET;
			height_reg = ids_pkg::HEIGHT_RESET;
			gain_reg = ids_pkg::GAIN_RESET;
			foreach (above_row[i]) begin
				above_row[i] = '0;
				centre_row[i] = '0;
			end
			left_px = '0;
			row_idx = 0;
			col_idx = 0;
			drain_idx = 0;
			pixel_beats = 0;
			drain_beats = 0;
			results_seen = 0;
			mismatches = 0;
		endfunction

		function int unsigned used_width();
			int unsigned w;
			w = width_reg;
			if (w < ids_pkg::MIN_DIM) w = ids_pkg::MIN_DIM;
			if (w > ids_pkg::MAX_WIDTH) w = ids_pkg::MAX_WIDTH;
			return w;
		endfunction

		function int unsigned used_height();
			int unsigned h;
			h = height_reg;
			if (h < ids_pkg::MIN_DIM) h = ids_pkg::MIN_DIM;
			if (h > ids_pkg::HEIGHT_LIMIT) h = ids_pkg::HEIGHT_LIMIT;
			return h;
		endfunction

		function void write_reg(ids_pkg::reg_idx_t idx,
				logic [ids_pkg::PDATA_BITS-1:0] value);
			case (idx)
				ids_pkg::REG_FRAME_WIDTH: width_reg = value[ids_pkg::WIDTH_BITS-1:0];
				ids_pkg::REG_FRAME_HEIGHT: height_reg = value[ids_pkg::HEIGHT_BITS-1:0];
				ids_pkg::REG_DIFFUSION_GAIN: gain_reg = value[ids_pkg::GAIN_BITS-1:0];
				default: ;
			endcase
		endfunction

		// u + kappa*laplacian, floor on the fraction, clipped to the pixel range
		function logic [ids_pkg::PIXEL_BITS-1:0] smooth(logic [ids_pkg::PIXEL_BITS-1:0] u,
				up, lf, rt, dn);
			longint lap, v;
			lap = longint'(up) + longint'(lf) + longint'(rt) + longint'(dn) - 4 * longint'(u);
			v = longint'(u) + ((lap * longint'(gain_reg)) >>> ids_pkg::FRAC_BITS);
			if (v < 0) v = 0;
			else if (v > PIX_MAX) v = PIX_MAX;
			return v[ids_pkg::PIXEL_BITS-1:0];
		endfunction

		function void note_input(ids_pkg::in_item_t beat);
			int unsigned w, h, c;
			logic [ids_pkg::PIXEL_BITS-1:0] old_c, old_a;
			ids_pkg::out_item_t e;
			w = used_width();
			h = used_height();
			if (beat.op == ids_pkg::OP_DRAIN) begin
				drain_beats++;
				if (drain_idx >= w) drain_idx = 0;
				e.out_pixel = centre_row[drain_idx];
				e.end_of_frame = (drain_idx == w - 1);
				drain_idx = e.end_of_frame ? 0 : drain_idx + 1;
				pending.push_back(e);
				return;
			end
			pixel_beats++;
			if (col_idx >= w) begin
				col_idx = 0;
				row_idx++;
			end
			if (row_idx >= h) row_idx = 0;
			c = col_idx;
			old_c = centre_row[c];
			old_a = above_row[c];
			if (row_idx >= 1) begin
				if (row_idx == 1 || c == 0 || c == w - 1) e.out_pixel = old_c;
				else e.out_pixel = smooth(old_c, old_a, left_px, centre_row[c + 1], beat.in_pixel);
				e.end_of_frame = 1'b0;
				pending.push_back(e);
			end
			left_px = old_c;
			above_row[c] = old_c;
			centre_row[c] = beat.in_pixel;
			col_idx = c + 1;
			if (col_idx >= w) begin
				col_idx = 0;
				row_idx++;
				if (row_idx >= h) row_idx = 0;
			end
		endfunction

		function void check_result(ids_pkg::out_item_t got);
			ids_pkg::out_item_t e;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("unexpected result beat %0d: pixel %h eof %b",
						results_seen, got.out_pixel, got.end_of_frame);
				return;
			end
			e = pending.pop_front();
			if (got.out_pixel !== e.out_pixel || got.end_of_frame !== e.end_of_frame) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("result %0d: expected pixel %h eof %b, got pixel %h eof %b",
						results_seen, e.out_pixel, e.end_of_frame,
						got.out_pixel, got.end_of_frame);
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [ids_pkg::PADDR_BITS-1:0] paddr = '0;
	logic [ids_pkg::PDATA_BITS-1:0] pwdata = '0;
	logic [ids_pkg::PDATA_BITS-1:0] prdata;
	logic                           pready;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	ids_pkg::in_item_t              in_data = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	ids_pkg::out_item_t             out_data;

	diffusion_scoreboard sb;
	logic        hold_req = 1'b0;
	bit          bursty = 1'b0;
	int unsigned burst_left = 0;
	int unsigned beats_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned stall_cycles = 0;

	isotropic_diffusion_stencil_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				sb.write_reg(ids_pkg::reg_idx_t'(paddr[ids_pkg::PADDR_BITS-1:2]), pwdata);
			if (in_valid && in_ready) sb.note_input(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
			stall_cycles <= stall_cycles + 1;
		else
			stall_cycles <= 0;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no beat for %0d cycles, %0d results outstanding",
				stall_cycles, sb.pending.size());
			$display("isotropic_diffusion_stencil_unit_tb NOT OK");
			$finish;
		end
	end

	// receiver: changing stall pattern, plus a long hold-off on request
	initial begin : receiver
		rx_mode_t mode;
		int unsigned tick;
		mode = RX_STREAM;
		tick = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req <= 1'b0;
			end else begin
				if (tick % 50 == 0) mode = rx_mode_t'($urandom_range(0, 3));
				case (mode)
					RX_STREAM: out_ready <= 1'b1;
					RX_CADENCE: out_ready <= (tick % 4 != 3);
					RX_COIN: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 7) == 0);
				endcase
				tick++;
			end
		end
	end

	function automatic logic [ids_pkg::PIXEL_BITS-1:0] pick_pixel(pix_style_t style,
			logic [ids_pkg::PIXEL_BITS-1:0] base);
		case (style)
			PIX_NOISE: return ids_pkg::PIXEL_BITS'($urandom);
			PIX_EXTREME: begin
				if ($urandom_range(0, 3) == 0) return ids_pkg::PIXEL_BITS'($urandom);
				return $urandom_range(0, 1) ? '1 : '0;
			end
			default: return base + ids_pkg::PIXEL_BITS'($urandom_range(0, 255))
				- ids_pkg::PIXEL_BITS'(128);
		endcase
	endfunction

	task automatic offer(ids_pkg::op_t op, logic [ids_pkg::PIXEL_BITS-1:0] px);
		ids_pkg::in_item_t beat;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = bursty ? $urandom_range(0, 7) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		beat.op = op;
		beat.in_pixel = px;
		in_data <= beat;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		beats_sent++;
	endtask

	// stop offering and let every outstanding result come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(ids_pkg::reg_idx_t idx, logic [ids_pkg::PDATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ids_pkg::PADDR_BITS'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(logic [ids_pkg::PDATA_BITS-1:0] w, h, g);
		wait_drained();
		reg_write(ids_pkg::REG_FRAME_WIDTH, w);
		reg_write(ids_pkg::REG_FRAME_HEIGHT, h);
		reg_write(ids_pkg::REG_DIFFUSION_GAIN, g);
		@(posedge clk);
	endtask

	// one whole frame at the current geometry, then tail_drains drain beats for its last row
	task automatic stream_frame(int unsigned tail_drains, bit noisy);
		int unsigned w, h, r, c, k;
		pix_style_t style;
		logic [ids_pkg::PIXEL_BITS-1:0] base;
		w = sb.used_width();
		h = sb.used_height();
		style = pix_style_t'($urandom_range(0, 2));
		base = ids_pkg::PIXEL_BITS'($urandom);
		for (r = 0; r < h; r++) begin
			for (c = 0; c < w; c++) begin
				// stray drains once a full row is stored
				if (noisy && r != 0 && $urandom_range(0, 63) == 0)
					for (k = $urandom_range(1, 3); k != 0; k--)
						offer(ids_pkg::OP_DRAIN, ids_pkg::PIXEL_BITS'($urandom));
				offer(ids_pkg::OP_PIXEL, pick_pixel(style, base));
			end
		end
		for (k = 0; k < tail_drains; k++)
			offer(ids_pkg::OP_DRAIN, ids_pkg::PIXEL_BITS'($urandom));
		frames_sent++;
	endtask

	initial begin : stimulus
		int unsigned i, r, w, f, nframes, random_start;
		logic [ids_pkg::PDATA_BITS-1:0] wv, hv, gv;
		bit first_hold;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturation both ways and a floor of minus one on a small frame
		set_regs(7, 3, 32'h0000FFFF);
		for (i = 0; i < 21; i++) offer(ids_pkg::OP_PIXEL, FRAME_B[i]);
		repeat (7) offer(ids_pkg::OP_DRAIN, ids_pkg::PIXEL_BITS'($urandom));

		// mid-frame drains, then stale column, row and drain indices after shrinking
		set_regs(5, 5, 32'h00008000);
		repeat (8) offer(ids_pkg::OP_PIXEL, ids_pkg::PIXEL_BITS'($urandom));
		repeat (4) offer(ids_pkg::OP_DRAIN, ids_pkg::PIXEL_BITS'($urandom));
		wait_drained();
		reg_write(ids_pkg::REG_FRAME_WIDTH, 2);
		repeat (3) offer(ids_pkg::OP_PIXEL, ids_pkg::PIXEL_BITS'($urandom));
		wait_drained();
		reg_write(ids_pkg::REG_FRAME_HEIGHT, 0);
		repeat (9) offer(ids_pkg::OP_PIXEL, ids_pkg::PIXEL_BITS'($urandom));
		repeat (3) offer(ids_pkg::OP_DRAIN, ids_pkg::PIXEL_BITS'($urandom));

		first_hold = 1'b1;
		random_start = beats_sent;
		while (beats_sent - random_start < RANDOM_BEATS) begin
			r = $urandom_range(0, 15);
			wv = (r == 0) ? $urandom_range(0, 2) : (r == 1) ? $urandom_range(21, 64) :
				$urandom_range(3, 20);
			r = $urandom_range(0, 15);
			hv = (r == 0) ? $urandom_range(0, 2) : (r == 1) ? $urandom_range(7, 16) :
				$urandom_range(3, 6);
			r = $urandom_range(0, 3);
			gv = (r == 0) ? 0 : (r == 1) ? 32'h0000FFFF : $urandom_range(0, 65535);
			set_regs(wv, hv, gv);
			bursty = ($urandom_range(0, 3) != 0);
			nframes = $urandom_range(1, 3);
			for (f = 0; f < nframes; f++) begin
				if (!hold_req && (first_hold || $urandom_range(0, 11) == 0)) begin
					hold_req <= 1'b1;
					first_hold = 1'b0;
				end
				w = sb.used_width();
				stream_frame(($urandom_range(0, 7) == 0) ? $urandom_range(w - 2, w + 2) : w, 1'b1);
				if ($urandom_range(0, 3) == 0) wait_drained();
			end
		end

		wait_drained();
		$display("%0d pixel and %0d drain beats in %0d frames, %0d results checked, %0d bad",
			sb.pixel_beats, sb.drain_beats, frames_sent, sb.results_seen, sb.mismatches);
		$display("frames 3 to 64 wide and 3 to 16 tall with clamped small sizes, gain 0..65535,");
		$display("stale indices, stray and partial drains, long output stalls");
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("isotropic_diffusion_stencil_unit_tb OK");
		else
			$display("isotropic_diffusion_stencil_unit_tb NOT OK");
		$finish;
	end

endmodule

[isotropic_diffusion_stencil_unit.f]
hdl/ids_pkg.sv
hdl/ids_cfg_regs.sv
hdl/ids_line_buf.sv
hdl/ids_diffuse.sv
hdl/isotropic_diffusion_stencil_unit.sv
test/isotropic_diffusion_stencil_unit_tb.sv
